[rtl/core/lsrl_pkg.sv]
// ----------------------------------------------------------------------------
// lsrl_pkg
// Shared types and constants of the lamp surge and recharge level block.
// ----------------------------------------------------------------------------
package lsrl_pkg;

	localparam logic [7:0]  LEVEL_CEILING = 8'd255;
	localparam logic [31:0] CHARGE_DIV    = 32'd100000;
	localparam logic [31:0] MS_PER_S      = 32'd1000;

	localparam logic [2:0] REG_LEVEL_FLOOR = 3'd0;
	localparam logic [2:0] REG_SURGE_MIN   = 3'd1;
	localparam logic [2:0] REG_SURGE_MAX   = 3'd2;
	localparam logic [2:0] REG_DROP_MIN    = 3'd3;
	localparam logic [2:0] REG_DROP_MAX    = 3'd4;
	localparam logic [2:0] REG_GAP_MIN     = 3'd5;
	localparam logic [2:0] REG_GAP_MAX     = 3'd6;
	localparam logic [2:0] REG_RATE        = 3'd7;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_CH_DIFF,
		OP_CH_MUL,
		OP_CH_APPLY,
		OP_SG_DRAW,
		OP_SG_SCALE,
		OP_SG_BEGIN,
		OP_GP_DRAW,
		OP_GP_SCALE,
		OP_GP_END,
		OP_IP_PREP,
		OP_IP_MUL,
		OP_IP_APPLY,
		OP_PUBLISH
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CH_DIFF,
		ST_CH_MUL,
		ST_CH_DIV,
		ST_CH_WAIT,
		ST_CH_APPLY,
		ST_SG_DRAW,
		ST_SG_SCALE,
		ST_SG_BEGIN,
		ST_SG_TEST,
		ST_GP_DRAW,
		ST_GP_SCALE,
		ST_GP_END,
		ST_IP_PREP,
		ST_IP_DIV,
		ST_IP_WAIT,
		ST_IP_MUL,
		ST_IP_APPLY,
		ST_FINAL,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   div_start;
	} dp_cmd_t;

	typedef struct packed {
		logic gt_start;
		logic gt_end;
		logic active;
		logic div_done;
	} dp_stat_t;

endpackage

[rtl/core/lsrl_div.sv]
// ----------------------------------------------------------------------------
// lsrl_div
// Iterative restoring divider with an 8-bit quotient saturated at 255.
// ----------------------------------------------------------------------------
module lsrl_div import lsrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [7:0]  quotient
);

	logic        busy_q;
	logic        done_q;
	logic [2:0]  cnt_q;
	logic [39:0] rem_q;
	logic [31:0] dvs_q;
	logic [7:0]  quo_q;
	logic [39:0] trial;
	logic        sat;
	logic        fits;

	assign sat   = dividend >= {8'b0, divisor, 8'b0};
	assign trial = {8'b0, dvs_q} << cnt_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				cnt_q  <= 3'd7;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= dividend[39:0];
			quo_q <= sat ? 8'hFF : 8'h00;
		end else if (busy_q) begin
			quo_q <= {quo_q[6:0], fits};
			if (fits) begin
				rem_q <= rem_q - trial;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/lsrl_dp.sv]
// ----------------------------------------------------------------------------
// lsrl_dp
// Datapath: configuration, lamp state, arithmetic steps and output word.
// ----------------------------------------------------------------------------
module lsrl_dp import lsrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [31:0] now_ms,
	input  logic [15:0] rand_duration,
	input  logic [7:0]  rand_drop,
	input  logic [15:0] rand_gap,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [7:0]  lamp_level,
	output logic        surging
);

	logic [7:0]  level_floor_q;
	logic [15:0] surge_min_q;
	logic [15:0] surge_max_q;
	logic [7:0]  drop_min_q;
	logic [7:0]  drop_max_q;
	logic [15:0] gap_min_q;
	logic [15:0] gap_max_q;
	logic [15:0] rate_q;

	logic        active_q;
	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [31:0] last_q;
	logic [7:0]  level_q;
	logic [7:0]  lvl_start_q;
	logic [7:0]  target_q;

	logic [31:0] now_q;
	logic [15:0] rdur_q;
	logic [7:0]  rdrop_q;
	logic [15:0] rgap_q;
	logic [31:0] t_q;
	logic [47:0] prod_q;
	logic [31:0] divisor_q;
	logic [31:0] draw16_q;
	logic [15:0] draw8_q;
	logic [15:0] dur_q;
	logic [7:0]  drop_q;
	logic [16:0] lerp_q;
	logic        up_q;
	logic [7:0]  lamp_level_q;
	logic        surging_q;

	logic [31:0] upto;
	logic [8:0]  sum9;
	logic [7:0]  low;
	logic [31:0] pos;
	logic [39:0] frac_num;
	logic        up;
	logic [7:0]  delta;
	logic [8:0]  frac_p1;
	logic [7:0]  step;
	logic        div_done;
	logic [7:0]  quo;

	lsrl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign upto     = (now_q < start_q) ? now_q : start_q;
	assign sum9     = {1'b0, level_q} + {1'b0, quo};
	assign low      = (level_q > drop_q) ? (level_q - drop_q) : 8'd0;
	assign pos      = now_q - start_q;
	assign frac_num = {pos, 8'b0} - {8'b0, pos};
	assign up       = target_q > lvl_start_q;
	assign delta    = up ? (target_q - lvl_start_q) : (lvl_start_q - target_q);
	assign frac_p1  = {1'b0, quo} + 9'd1;
	assign step     = lerp_q[15:8];

	assign stat.gt_start = now_q > start_q;
	assign stat.gt_end   = now_q > end_q;
	assign stat.active   = active_q;
	assign stat.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_floor_q <= 8'd0;
			surge_min_q   <= 16'd1;
			surge_max_q   <= 16'd5;
			drop_min_q    <= 8'd20;
			drop_max_q    <= 8'd100;
			gap_min_q     <= 16'd10;
			gap_max_q     <= 16'd60;
			rate_q        <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEVEL_FLOOR: level_floor_q <= cfg_data[7:0];
				REG_SURGE_MIN:   surge_min_q   <= cfg_data;
				REG_SURGE_MAX:   surge_max_q   <= cfg_data;
				REG_DROP_MIN:    drop_min_q    <= cfg_data[7:0];
				REG_DROP_MAX:    drop_max_q    <= cfg_data[7:0];
				REG_GAP_MIN:     gap_min_q     <= cfg_data;
				REG_GAP_MAX:     gap_max_q     <= cfg_data;
				REG_RATE:        rate_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			start_q     <= 32'd0;
			end_q       <= 32'd0;
			last_q      <= 32'd0;
			level_q     <= LEVEL_CEILING;
			lvl_start_q <= 8'd0;
			target_q    <= 8'd0;
		end else begin
			case (cmd.op)
				OP_CH_DIFF: begin
					last_q <= upto;
				end
				OP_CH_APPLY: begin
					level_q <= (sum9 > {1'b0, LEVEL_CEILING}) ? LEVEL_CEILING : sum9[7:0];
				end
				OP_SG_BEGIN: begin
					end_q       <= now_q + ({16'b0, dur_q} * MS_PER_S);
					lvl_start_q <= level_q;
					target_q    <= (low > level_floor_q) ? low : level_floor_q;
					active_q    <= 1'b1;
				end
				OP_GP_END: begin
					active_q <= 1'b0;
					level_q  <= target_q;
					last_q   <= end_q;
					start_q  <= end_q + ({16'b0, dur_q} * MS_PER_S);
				end
				OP_IP_APPLY: begin
					level_q <= up_q ? (lvl_start_q + step) : (lvl_start_q - step);
					last_q  <= now_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				now_q   <= now_ms;
				rdur_q  <= rand_duration;
				rdrop_q <= rand_drop;
				rgap_q  <= rand_gap;
			end
			OP_CH_DIFF: begin
				t_q <= upto - last_q;
			end
			OP_CH_MUL: begin
				prod_q    <= {16'b0, t_q} * {32'b0, rate_q};
				divisor_q <= CHARGE_DIV;
			end
			OP_SG_DRAW: begin
				draw16_q <= {16'b0, rdur_q} * {16'b0, surge_max_q - surge_min_q};
				draw8_q  <= {8'b0, rdrop_q} * {8'b0, drop_max_q - drop_min_q};
			end
			OP_SG_SCALE: begin
				dur_q  <= surge_min_q + draw16_q[31:16];
				drop_q <= drop_min_q + draw8_q[15:8];
			end
			OP_GP_DRAW: begin
				draw16_q <= {16'b0, rgap_q} * {16'b0, gap_max_q - gap_min_q};
			end
			OP_GP_SCALE: begin
				dur_q <= gap_min_q + draw16_q[31:16];
			end
			OP_IP_PREP: begin
				prod_q    <= {8'b0, frac_num};
				divisor_q <= end_q - start_q;
			end
			OP_IP_MUL: begin
				lerp_q <= {9'b0, delta} * {8'b0, frac_p1};
				up_q   <= up;
			end
			OP_PUBLISH: begin
				lamp_level_q <= level_q;
				surging_q    <= active_q;
			end
			default: ;
		endcase
	end

	assign lamp_level = lamp_level_q;
	assign surging    = surging_q;

endmodule

[rtl/core/lsrl_ctrl.sv]
// ----------------------------------------------------------------------------
// lsrl_ctrl
// Controller: sequences charge, surge and interpolation steps for one word.
// ----------------------------------------------------------------------------
module lsrl_ctrl import lsrl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	logic        final_q;
	logic        final_n;
	logic        out_valid_q;
	logic        out_valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			final_q     <= final_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_comb begin
		state_n       = state_q;
		final_n       = final_q;
		out_valid_n   = out_valid_q && out_stall;
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.gt_start) begin
					if (!stat.active) begin
						final_n = 1'b0;
						state_n = ST_CH_DIFF;
					end else begin
						state_n = ST_SG_TEST;
					end
				end else begin
					state_n = ST_FINAL;
				end
			end
			ST_CH_DIFF: begin
				cmd.op  = OP_CH_DIFF;
				state_n = ST_CH_MUL;
			end
			ST_CH_MUL: begin
				cmd.op  = OP_CH_MUL;
				state_n = ST_CH_DIV;
			end
			ST_CH_DIV: begin
				cmd.div_start = 1'b1;
				state_n       = ST_CH_WAIT;
			end
			ST_CH_WAIT: begin
				if (stat.div_done) begin
					state_n = ST_CH_APPLY;
				end
			end
			ST_CH_APPLY: begin
				cmd.op  = OP_CH_APPLY;
				state_n = final_q ? ST_DONE : ST_SG_DRAW;
			end
			ST_SG_DRAW: begin
				cmd.op  = OP_SG_DRAW;
				state_n = ST_SG_SCALE;
			end
			ST_SG_SCALE: begin
				cmd.op  = OP_SG_SCALE;
				state_n = ST_SG_BEGIN;
			end
			ST_SG_BEGIN: begin
				cmd.op  = OP_SG_BEGIN;
				state_n = ST_SG_TEST;
			end
			ST_SG_TEST: begin
				state_n = stat.gt_end ? ST_GP_DRAW : ST_IP_PREP;
			end
			ST_GP_DRAW: begin
				cmd.op  = OP_GP_DRAW;
				state_n = ST_GP_SCALE;
			end
			ST_GP_SCALE: begin
				cmd.op  = OP_GP_SCALE;
				state_n = ST_GP_END;
			end
			ST_GP_END: begin
				cmd.op  = OP_GP_END;
				state_n = ST_FINAL;
			end
			ST_IP_PREP: begin
				cmd.op  = OP_IP_PREP;
				state_n = ST_IP_DIV;
			end
			ST_IP_DIV: begin
				cmd.div_start = 1'b1;
				state_n       = ST_IP_WAIT;
			end
			ST_IP_WAIT: begin
				if (stat.div_done) begin
					state_n = ST_IP_MUL;
				end
			end
			ST_IP_MUL: begin
				cmd.op  = OP_IP_MUL;
				state_n = ST_IP_APPLY;
			end
			ST_IP_APPLY: begin
				cmd.op  = OP_IP_APPLY;
				state_n = ST_FINAL;
			end
			ST_FINAL: begin
				if (!stat.active) begin
					final_n = 1'b1;
					state_n = ST_CH_DIFF;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op      = OP_PUBLISH;
					out_valid_n = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

[rtl/core/lamp_surge_recharge_level_core.sv]
// ----------------------------------------------------------------------------
// lamp_surge_recharge_level_core
// Lamp level model with time-based recharge and random surges.
// ----------------------------------------------------------------------------
// Each input word carries a millisecond timestamp and three raw random draws;
// each one yields exactly one output word with the lamp level and the surge
// flag after the update. Both channels use valid and stall, and a word moves
// at a clock edge where valid is high and stall is low.
// One word is processed at a time. The time from acceptance to its result
// depends on the path it takes and on the eight-step iterative divider, which
// is used once for each recharge step and once for each interpolation step of
// a surge and skips its steps when its quotient saturates.
// The next word is accepted as soon as the previous result sits in the output
// register, even while the receiver still stalls it; a finished result then
// waits until the output register is free. The configuration registers are
// written through cfg_we, cfg_index and cfg_data and take effect at once; the
// user must write them only while the block is idle, which the block itself
// does not enforce.
// Reset clears the lamp state to full level with no surge in progress, loads
// the default configuration and empties the output register.
// ----------------------------------------------------------------------------
module lamp_surge_recharge_level_core import lsrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	input  logic [15:0] rand_duration,
	input  logic [7:0]  rand_drop,
	input  logic [15:0] rand_gap,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  lamp_level,
	output logic        surging
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lsrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lsrl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.now_ms        (now_ms),
		.rand_duration (rand_duration),
		.rand_drop     (rand_drop),
		.rand_gap      (rand_gap),
		.cmd           (cmd),
		.stat          (stat),
		.lamp_level    (lamp_level),
		.surging       (surging)
	);

endmodule

[tb/lamp_surge_recharge_level_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamp_surge_recharge_level_core_tb
// Self-checking bench for the lamp surge and recharge level core.
// ----------------------------------------------------------------------------
// A queue of timestamped words feeds a clocked driver. Each accepted word is
// run through a bit-accurate model of the lamp state, and the expected level
// and surge flag are matched against the output words in order. The run walks
// through several register settings, including reversed bounds and all-zero
// and all-ones extremes; in all but the last two, both sides idle at random.
// ----------------------------------------------------------------------------
module lamp_surge_recharge_level_core_tb;
	import lsrl_pkg::*;

	localparam int RANDOM_PER_PHASE = 228;

	typedef struct packed {
		logic [31:0] now;
		logic [15:0] dur_draw;
		logic [7:0]  drop_draw;
		logic [15:0] gap_draw;
	} lamp_word_t;

	typedef struct packed {
		logic [7:0] level;
		logic       surging;
	} lamp_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_LEVEL_FLOOR;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] now_ms = 32'd0;
	logic [15:0] rand_duration = 16'd0;
	logic [7:0]  rand_drop = 8'd0;
	logic [15:0] rand_gap = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  lamp_level;
	logic        surging;

	lamp_surge_recharge_level_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.now_ms        (now_ms),
		.rand_duration (rand_duration),
		.rand_drop     (rand_drop),
		.rand_gap      (rand_gap),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.lamp_level    (lamp_level),
		.surging       (surging)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lamp_word_t  words_to_send [$];
	lamp_state_t levels_due [$];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatches = 0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          settings_applied = 0;
	int          surges_begun = 0;
	int          surges_done = 0;
	logic [31:0] clock_ms = 32'd0;

	logic [15:0] reg_file [0:7] = '{16'd0, 16'd1, 16'd5, 16'd20, 16'd100, 16'd10, 16'd60,
		16'd100};

	logic        in_surge = 1'b0;
	logic [31:0] surge_from_ms = 32'd0;
	logic [31:0] surge_to_ms = 32'd0;
	logic [31:0] charged_ms = 32'd0;
	logic [7:0]  lvl_now = LEVEL_CEILING;
	logic [7:0]  lvl_from = 8'd0;
	logic [7:0]  lvl_to = 8'd0;

	function automatic logic [15:0] scale16(logic [15:0] draw, logic [15:0] lo, logic [15:0] hi);
		logic [15:0] span;
		logic [31:0] prod;
		span = hi - lo;
		prod = draw * span;
		return lo + prod[31:16];
	endfunction

	function automatic void charge_to(logic [31:0] now);
		logic [31:0] upto;
		logic [31:0] span;
		logic [63:0] gain;
		logic [9:0]  sum;
		upto = (now < surge_from_ms) ? now : surge_from_ms;
		span = upto - charged_ms;
		gain = span * reg_file[REG_RATE] / CHARGE_DIV;
		if (gain > 64'd255)
			gain = 64'd255;
		sum = lvl_now + gain[7:0];
		lvl_now = (sum > LEVEL_CEILING) ? LEVEL_CEILING : sum[7:0];
		charged_ms = upto;
	endfunction

	function automatic lamp_state_t advance_lamp(lamp_word_t w);
		logic [15:0] dur;
		logic [15:0] gap;
		logic [7:0]  dspan;
		logic [15:0] dprod;
		logic [7:0]  drop;
		logic [7:0]  low;
		logic [7:0]  delta;
		logic [15:0] lerp;
		logic [31:0] pos;
		logic [31:0] total;
		logic [63:0] frac;
		lamp_state_t r;
		if (w.now > surge_from_ms) begin
			if (!in_surge) begin
				charge_to(w.now);
				dur = scale16(w.dur_draw, reg_file[REG_SURGE_MIN], reg_file[REG_SURGE_MAX]);
				dspan = reg_file[REG_DROP_MAX][7:0] - reg_file[REG_DROP_MIN][7:0];
				dprod = w.drop_draw * dspan;
				drop = reg_file[REG_DROP_MIN][7:0] + dprod[15:8];
				low = (lvl_now > drop) ? lvl_now - drop : 8'd0;
				surge_to_ms = w.now + MS_PER_S * dur;
				lvl_from = lvl_now;
				lvl_to = (low > reg_file[REG_LEVEL_FLOOR][7:0]) ? low :
					reg_file[REG_LEVEL_FLOOR][7:0];
				in_surge = 1'b1;
				surges_begun++;
			end
			if (w.now > surge_to_ms) begin
				gap = scale16(w.gap_draw, reg_file[REG_GAP_MIN], reg_file[REG_GAP_MAX]);
				in_surge = 1'b0;
				lvl_now = lvl_to;
				charged_ms = surge_to_ms;
				surge_from_ms = surge_to_ms + MS_PER_S * gap;
				surges_done++;
			end else begin
				pos = w.now - surge_from_ms;
				total = surge_to_ms - surge_from_ms;
				frac = 64'd255;
				if (total != 32'd0)
					frac = 64'd255 * pos / total;
				if (frac > 64'd255)
					frac = 64'd255;
				delta = (lvl_to > lvl_from) ? lvl_to - lvl_from : lvl_from - lvl_to;
				lerp = delta * frac[7:0] + delta;
				lvl_now = (lvl_to > lvl_from) ? lvl_from + lerp[15:8] : lvl_from - lerp[15:8];
				charged_ms = w.now;
			end
		end
		if (!in_surge)
			charge_to(w.now);
		r.level = lvl_now;
		r.surging = in_surge;
		return r;
	endfunction

	function automatic void flag_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin : lamp_driver
		lamp_word_t w;
		lamp_word_t seen;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				seen.now = now_ms;
				seen.dur_draw = rand_duration;
				seen.drop_draw = rand_drop;
				seen.gap_draw = rand_gap;
				levels_due.push_back(advance_lamp(seen));
				words_sent++;
			end
			if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				w = words_to_send.pop_front();
				in_valid <= 1'b1;
				now_ms <= w.now;
				rand_duration <= w.dur_draw;
				rand_drop <= w.drop_draw;
				rand_gap <= w.gap_draw;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : lamp_monitor
		lamp_state_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_checked++;
				if (levels_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected word: level %0d surging %0b",
						lamp_level, surging));
				end else begin
					want = levels_due.pop_front();
					if (lamp_level !== want.level)
						flag_mismatch($sformatf("lamp_level: expected %0d, got %0d",
							want.level, lamp_level));
					if (surging !== want.surging)
						flag_mismatch($sformatf("surging: expected %0b, got %0b",
							want.surging, surging));
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic queue_word(logic [31:0] now, logic [15:0] dur, logic [7:0] drop,
		logic [15:0] gap);
		lamp_word_t w;
		w.now = now;
		w.dur_draw = dur;
		w.drop_draw = drop;
		w.gap_draw = gap;
		words_to_send.push_back(w);
	endtask

	task automatic settle();
		do begin
			@(posedge clk);
			#1;
		end while (words_to_send.size() != 0 || in_valid || levels_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_file[idx] = val;
	endtask

	task automatic load_setting(input logic [15:0] floor_v, smin, smax, dmin, dmax, gmin, gmax,
		rate);
		write_reg(REG_LEVEL_FLOOR, floor_v);
		write_reg(REG_SURGE_MIN, smin);
		write_reg(REG_SURGE_MAX, smax);
		write_reg(REG_DROP_MIN, dmin);
		write_reg(REG_DROP_MAX, dmax);
		write_reg(REG_GAP_MIN, gmin);
		write_reg(REG_GAP_MAX, gmax);
		write_reg(REG_RATE, rate);
		settings_applied++;
	endtask

	// Called only while idle, so the model state tells where the lamp's clock stands.
	task automatic queue_timeline(int count);
		int pick;
		if (in_surge && clock_ms < surge_to_ms)
			clock_ms = surge_to_ms;
		if (!in_surge && clock_ms < surge_from_ms)
			clock_ms = surge_from_ms;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 70)
				clock_ms += $urandom_range(0, 1500);
			else if (pick < 88)
				clock_ms += $urandom_range(0, 8000);
			else if (pick < 94)
				clock_ms += $urandom_range(0, 120000);
			else if (pick < 97)
				clock_ms += $urandom_range(0, 70000000);
			else if (pick < 99)
				clock_ms -= $urandom_range(0, 3000);
			else begin
				queue_word($urandom(), 16'($urandom()), 8'($urandom()), 16'($urandom()));
				continue;
			end
			queue_word(clock_ms, 16'($urandom()), 8'($urandom()), 16'($urandom()));
		end
	endtask

	task automatic run_phase(input logic [15:0] floor_v, smin, smax, dmin, dmax, gmin, gmax,
		rate);
		load_setting(floor_v, smin, smax, dmin, dmax, gmin, gmax, rate);
		queue_timeline(RANDOM_PER_PHASE);
		settle();
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 25;
		recv_idle_pct = 76;

		load_setting(16'd0, 16'd1, 16'd5, 16'd20, 16'd100, 16'd10, 16'd60, 16'd100);
		queue_word(32'd0, 16'h0000, 8'h00, 16'h0000);
		queue_word(32'd1, 16'hFFFF, 8'hFF, 16'hFFFF);
		queue_word(32'd2001, 16'h0000, 8'h00, 16'h0000);
		queue_word(32'd4001, 16'h1234, 8'h5A, 16'h0000);
		queue_word(32'd4002, 16'h0000, 8'h00, 16'hFFFF);
		queue_word(32'd30000, 16'h0000, 8'h00, 16'h0000);
		queue_word(32'd63001, 16'h0000, 8'h00, 16'h0000);
		queue_word(32'd63002, 16'h0000, 8'h00, 16'h0000);
		queue_word(32'd63500, 16'h8000, 8'h80, 16'h8000);
		queue_word(32'd64003, 16'h0000, 8'h00, 16'h0000);
		queue_word(32'd80000, 16'hFFFF, 8'hFF, 16'hFFFF);
		queue_word(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		queue_word(32'h0000_0005, 16'h0000, 8'h00, 16'h0000);
		queue_word(32'h8000_0000, 16'h7FFF, 8'h7F, 16'h7FFF);
		queue_word(32'hAAAA_AAAA, 16'h5555, 8'hAA, 16'h5555);
		queue_word(32'h5555_5555, 16'hAAAA, 8'h55, 16'hAAAA);
		queue_word(32'hFFFF_FFFF, 16'h0001, 8'h01, 16'h0001);
		queue_word(32'd0, 16'hFFFF, 8'hFF, 16'hFFFF);
		settle();
		queue_timeline(RANDOM_PER_PHASE);
		settle();

		run_phase(16'd0, 16'd0, 16'd3, 16'd0, 16'd255, 16'd0, 16'd4, 16'd65535);
		run_phase(16'd255, 16'd2, 16'd2, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0);

		send_idle_pct = 76;
		recv_idle_pct = 25;
		run_phase(16'd40, 16'd65535, 16'd1, 16'd255, 16'd10, 16'd65535, 16'd1, 16'd500);
		run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_phase(16'd0, 16'd0, 16'd65535, 16'd0, 16'd255, 16'd0, 16'd65535, 16'd65535);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(16'($urandom_range(0, 255)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 8)), 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 255)), 16'($urandom_range(0, 5)),
			16'($urandom_range(0, 30)), 16'($urandom_range(0, 65535)));
		// The last stretch crosses the wrap of the millisecond counter.
		if (clock_ms < 32'hFFF0_0000)
			clock_ms = 32'hFFF0_0000;
		run_phase(16'($urandom_range(0, 255)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 8)), 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 255)), 16'($urandom_range(0, 5)),
			16'($urandom_range(0, 30)), 16'($urandom_range(0, 65535)));

		repeat (50) @(posedge clk);
		$display("Sent %0d lamp words under %0d register settings; %0d output words checked.",
			words_sent, settings_applied, words_checked);
		$display("The model saw %0d surges begin and %0d run out; %0d mismatches.",
			surges_begun, surges_done, mismatches);
		if (mismatches == 0 && levels_due.size() == 0) begin
			$display("lamp_surge_recharge_level_core verification clean");
		end else begin
			$display("lamp_surge_recharge_level_core verification failed");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Run timed out with %0d words still expected.", levels_due.size());
		$display("lamp_surge_recharge_level_core verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/lsrl_pkg.sv
rtl/core/lsrl_div.sv
rtl/core/lsrl_dp.sv
rtl/core/lsrl_ctrl.sv
rtl/core/lamp_surge_recharge_level_core.sv
tb/lamp_surge_recharge_level_core_tb.sv
